>>> rtl/sldf_pkg.sv
// Shared types, constants and the CRC-8 step for the sync/length/CRC-8 deframer.
package sldf_pkg;

    localparam int WRITE_LIMIT = 256;
    localparam int WPOS_W      = $clog2(WRITE_LIMIT + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;
    localparam logic [7:0] CRC_POLY    = 8'h31;

    localparam logic [1:0] KIND_TYPE    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_NONE    = 2'd2;

    localparam logic [1:0] VERDICT_OPEN      = 2'd0;
    localparam logic [1:0] VERDICT_GOOD      = 2'd1;
    localparam logic [1:0] VERDICT_BAD       = 2'd2;
    localparam logic [1:0] VERDICT_TRUNCATED = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_write;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] byte_kind;
        logic [1:0] verdict;
        logic       frame_last;
    } out_item_t;

    // MSB-first CRC-8 over one byte
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/sldf_front.sv
// Byte parser: hunts sync, tracks header, length and CRC; at most one result per beat.
module sldf_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  sldf_pkg::in_item_t item,
    input  logic               queue_full,
    output logic               push,
    output sldf_pkg::out_item_t push_item
);
    import sldf_pkg::*;

    localparam logic [2:0] PH_HUNT1   = 3'd0;
    localparam logic [2:0] PH_HUNT2   = 3'd1;
    localparam logic [2:0] PH_LENH    = 3'd2;
    localparam logic [2:0] PH_LENL    = 3'd3;
    localparam logic [2:0] PH_TYPE    = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_CRC     = 3'd6;

    logic [2:0]        phase_reg, phase_next;
    logic [7:0]        len_hi_reg, len_hi_next;
    logic [15:0]       remaining_reg, remaining_next;
    logic [7:0]        crc_reg, crc_next;
    logic [WPOS_W-1:0] wpos_reg, wpos_next;
    logic              type_passed_reg, type_passed_next;

    logic       accept;
    logic       in_limit;
    logic       cut;
    logic       has_result;
    logic [7:0] crc_step;
    logic [7:0] b;

    assign item_stall = queue_full;
    assign accept     = item_valid && !queue_full;
    assign b          = item.data_byte;
    assign in_limit   = (wpos_reg != WPOS_W'(WRITE_LIMIT));
    assign crc_step   = crc8_feed((phase_reg == PH_TYPE) ? 8'd0 : crc_reg, b);

    always_comb
    begin
        phase_next       = phase_reg;
        len_hi_next      = len_hi_reg;
        remaining_next   = remaining_reg;
        crc_next         = crc_reg;
        wpos_next        = wpos_reg;
        type_passed_next = type_passed_reg;
        has_result       = 1'b0;
        push_item.out_byte   = 8'd0;
        push_item.byte_kind  = KIND_NONE;
        push_item.verdict    = VERDICT_OPEN;
        push_item.frame_last = 1'b0;
        cut = item.end_of_write || (wpos_reg == WPOS_W'(WRITE_LIMIT - 1));

        if (!in_limit)
        begin
            // past the limit: drop the beat, only the write end matters
            if (item.end_of_write)
            begin
                wpos_next = '0;
            end
        end
        else
        begin
            wpos_next = wpos_reg + 1'b1;
            unique case (phase_reg)
                PH_HUNT1:
                begin
                    if (b == SYNC_FIRST)
                    begin
                        phase_next = PH_HUNT2;
                    end
                end
                PH_HUNT2:
                begin
                    if (b == SYNC_SECOND)
                    begin
                        phase_next = PH_LENH;
                    end
                    else if (b != SYNC_FIRST)
                    begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_LENH:
                begin
                    len_hi_next = b;
                    phase_next  = PH_LENL;
                end
                PH_LENL:
                begin
                    remaining_next = {len_hi_reg, b};
                    phase_next     = PH_TYPE;
                end
                PH_TYPE:
                begin
                    crc_next             = crc_step;
                    type_passed_next     = 1'b1;
                    push_item.out_byte   = b;
                    push_item.byte_kind  = KIND_TYPE;
                    has_result           = 1'b1;
                    phase_next = (remaining_reg != 16'd0) ? PH_PAYLOAD : PH_CRC;
                end
                PH_PAYLOAD:
                begin
                    crc_next            = crc_step;
                    push_item.out_byte  = b;
                    push_item.byte_kind = KIND_PAYLOAD;
                    has_result          = 1'b1;
                    remaining_next      = remaining_reg - 16'd1;
                    if (remaining_reg == 16'd1)
                    begin
                        phase_next = PH_CRC;
                    end
                end
                PH_CRC:
                begin
                    push_item.verdict    = (b == crc_reg) ? VERDICT_GOOD : VERDICT_BAD;
                    push_item.frame_last = 1'b1;
                    has_result           = 1'b1;
                    phase_next           = PH_HUNT1;
                    remaining_next       = 16'd0;
                    len_hi_next          = 8'd0;
                    crc_next             = 8'd0;
                    type_passed_next     = 1'b0;
                end
                default:
                begin
                    phase_next       = PH_HUNT1;
                    remaining_next   = 16'd0;
                    len_hi_next      = 8'd0;
                    crc_next         = 8'd0;
                    type_passed_next = 1'b0;
                end
            endcase

            if (cut)
            begin
                // close an open frame as truncated, then hunt again; a type byte
                // on this beat already opens the frame
                if (type_passed_next)
                begin
                    push_item.verdict    = VERDICT_TRUNCATED;
                    push_item.frame_last = 1'b1;
                    has_result           = 1'b1;
                end
                phase_next       = PH_HUNT1;
                remaining_next   = 16'd0;
                len_hi_next      = 8'd0;
                crc_next         = 8'd0;
                type_passed_next = 1'b0;
                if (item.end_of_write)
                begin
                    wpos_next = '0;
                end
            end
        end
    end

    assign push = accept && has_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT1;
            len_hi_reg      <= 8'd0;
            remaining_reg   <= 16'd0;
            crc_reg         <= 8'd0;
            wpos_reg        <= '0;
            type_passed_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            len_hi_reg      <= len_hi_next;
            remaining_reg   <= remaining_next;
            crc_reg         <= crc_next;
            wpos_reg        <= wpos_next;
            type_passed_reg <= type_passed_next;
        end
    end

endmodule

>>> rtl/sldf_queue.sv
// Result queue between the parser and the output channel.
module sldf_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sldf_pkg::out_item_t push_item,
    output logic                full,
    output logic                res_valid,
    input  logic                res_stall,
    output sldf_pkg::out_item_t res
);
    import sldf_pkg::*;

    out_item_t         mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign res_valid = (count_reg != '0);
    assign res       = mem[rd_ptr_reg];
    assign pop       = res_valid && !res_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/sync_length_crc8_frame_deframer_top.sv
// Each result is registered in the queue when its byte is accepted and offered in order.
// Throughput: one byte per cycle unless the queue is full; the CRC-8 step is combinational.
// A two-entry result queue lets the input keep flowing while a result waits on the output.
// The input stalls only when that queue is full.
// Reset (rst_n low, asynchronous) returns the parser to sync hunt at write position zero
// and empties the queue.
module sync_length_crc8_frame_deframer_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  sldf_pkg::in_item_t  item,
    output logic                res_valid,
    input  logic                res_stall,
    output sldf_pkg::out_item_t res
);
    import sldf_pkg::*;

    logic      queue_full;
    logic      push;
    out_item_t push_item;

    sldf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    sldf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
